// ----- src/bgtm_pkg.sv -----
// bgtm_pkg: shared widths, register codes and structs of the band gap trace midpoint block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package bgtm_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned COL_W  = 12;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned HGT_W  = 13;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned LIM_W  = CNT_W + 1;
  localparam int unsigned D_W    = 11;
  localparam int unsigned PROD_W = 2 * ROW_W;
  localparam int unsigned NUM_BINS    = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_W      = 5;
  localparam int unsigned DATA_W      = 32;

  // floor(x/3) = (x * 2731) >> 13 for any 12-bit x
  localparam logic [ROW_W-1:0] RECIP3      = 12'd2731;
  localparam int unsigned      RECIP_SHIFT = 13;

  localparam logic [ROW_W-1:0] Y_MIN_RST   = 12'd0;
  localparam logic [ROW_W-1:0] Y_MAX_RST   = 12'd3;
  localparam logic [HGT_W-1:0] HEIGHT_RST  = 13'd4096;
  localparam logic [PIX_W-1:0] THRESH_RST  = 8'd127;
  localparam logic [CNT_W-1:0] MIN_CNT_RST = 8'd3;
  localparam logic [D_W-1:0]   D_RST       = D_W'((3 - 0) / 3);
  localparam logic [CNT_W-1:0] CNT_MAX     = 8'd255;

  typedef enum logic [2:0] {
    REG_Y_MIN     = 3'd0,
    REG_Y_MAX     = 3'd1,
    REG_HEIGHT    = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_MIN_COUNT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0] y_min;
    logic [ROW_W-1:0] y_max;
    logic [HGT_W-1:0] image_height;
    logic [PIX_W-1:0] dark_threshold;
    logic [CNT_W-1:0] min_count;
    logic [D_W-1:0]   d;
  } cfg_t;

  typedef struct packed {
    logic             dark;
    logic [ROW_W-1:0] row;
    logic             column_end;
    logic             image_end;
  } item_t;

endpackage

// ----- src/bgtm_front.sv -----
// bgtm_front: input register stage, marks dark in-band pixels
// depends on bgtm_pkg
`timescale 1ns / 1ps

module bgtm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bgtm_pkg::cfg_t            cfg_i,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [bgtm_pkg::PIX_W-1:0] pixel_i,
  input  logic [bgtm_pkg::ROW_W-1:0] row_i,
  input  logic                      column_end_i,
  input  logic                      image_end_i,
  output logic                      q_valid_o,
  input  logic                      q_ready_i,
  output bgtm_pkg::item_t           q_item_o
);

  logic            valid_r;
  bgtm_pkg::item_t item_r;
  logic            dark;

  assign dark = (row_i >= cfg_i.y_min) && (row_i <= cfg_i.y_max) &&
                (pixel_i < cfg_i.dark_threshold);

  assign in_tready = !valid_r || q_ready_i;
  assign q_valid_o = valid_r;
  assign q_item_o  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.dark       <= dark;
      item_r.row        <= row_i;
      item_r.column_end <= column_end_i;
      item_r.image_end  <= image_end_i;
    end
  end

endmodule

// ----- src/bgtm_queue.sv -----
// bgtm_queue: short fifo of classified pixels between front and back stages
// depends on bgtm_pkg
`timescale 1ns / 1ps

module bgtm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  bgtm_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output bgtm_pkg::item_t pop_item_o
);

  localparam int unsigned DEPTH = bgtm_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  bgtm_pkg::item_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign push_ready_o = (count_r != FULL_CNT);
  assign pop_valid_o  = (count_r != '0);
  assign pop_item_o   = mem_r[rd_ptr_r];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= FULL_CNT)
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == FULL_CNT) && !pop |=> (count_r == FULL_CNT))
    else $error("full queue lost an entry without a pop");
`endif

endmodule

// ----- src/bgtm_back.sv -----
// bgtm_back: per-bin dark counts, run tracking, cut row choice and result register
// depends on bgtm_pkg
`timescale 1ns / 1ps

module bgtm_back #(
  parameter int unsigned RUN_CAP = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bgtm_pkg::cfg_t             cfg_i,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  bgtm_pkg::item_t            q_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bgtm_pkg::COL_W-1:0] start_column_o,
  output logic [bgtm_pkg::LEN_W-1:0] run_length_o,
  output logic [bgtm_pkg::ROW_W-1:0] cut_row_o,
  output logic                       config_error_o
);

  localparam int unsigned ROW_W = bgtm_pkg::ROW_W;
  localparam int unsigned COL_W = bgtm_pkg::COL_W;
  localparam int unsigned LEN_W = bgtm_pkg::LEN_W;
  localparam int unsigned CNT_W = bgtm_pkg::CNT_W;
  localparam int unsigned LIM_W = bgtm_pkg::LIM_W;
  localparam int unsigned NB    = bgtm_pkg::NUM_BINS;
  localparam int unsigned SUM_W = ROW_W + 2;
  localparam logic [LEN_W-1:0] CAP = LEN_W'(RUN_CAP);

  logic             in_run_r, col_dark_r;
  logic [CNT_W-1:0] cnt_r [NB];
  logic [COL_W-1:0] cur_col_r, run_start_r;
  logic [LEN_W-1:0] run_cols_r;
  logic             out_valid_r, out_err_r;
  logic [COL_W-1:0] out_start_r;
  logic [LEN_W-1:0] out_len_r;
  logic [ROW_W-1:0] out_cut_r;

  logic             in_run_nxt, col_dark_nxt;
  logic [CNT_W-1:0] cnt_nxt [NB];
  logic [CNT_W-1:0] cnt_upd [NB];
  logic [COL_W-1:0] cur_col_nxt, run_start_nxt;
  logic [LEN_W-1:0] run_cols_nxt;
  logic             emit, emit_err;
  logic [COL_W-1:0] emit_start;
  logic [LEN_W-1:0] emit_len;
  logic [ROW_W-1:0] emit_cut;

  logic             fire, col_done, bad, dark_col;
  logic [ROW_W:0]   bnd_a, bnd_b, row_x;
  logic [SUM_W-1:0] sum_h, sum_m, sum_l;
  logic [ROW_W-1:0] mid_h, mid_m, mid_l, run_cut;
  logic [LIM_W-1:0] lim;
  logic [1:0]       bin_sel;
  logic [NB-1:0]    populated;

  assign fire      = q_valid_i && q_ready_o;
  assign q_ready_o = !out_valid_r || out_ready_i;

  // bin bounds and the three midpoints
  assign bnd_a = (ROW_W + 1)'(cfg_i.y_min) + (ROW_W + 1)'(cfg_i.d);
  assign bnd_b = bnd_a + (ROW_W + 1)'(cfg_i.d);
  assign row_x = {1'b0, q_item_i.row};
  assign sum_h = SUM_W'(cfg_i.y_min) + SUM_W'(bnd_a);
  assign sum_m = SUM_W'(bnd_a) + SUM_W'(bnd_b);
  assign sum_l = SUM_W'(bnd_b) + SUM_W'(cfg_i.y_max);
  assign mid_h = sum_h[ROW_W:1];
  assign mid_m = sum_m[ROW_W:1];
  assign mid_l = sum_l[ROW_W:1];

  assign lim = (cfg_i.min_count == bgtm_pkg::CNT_MAX) ? LIM_W'(bgtm_pkg::CNT_MAX)
                                                      : LIM_W'(cfg_i.min_count) + 1'b1;
  assign bin_sel = (row_x < bnd_a) ? 2'd0 : (row_x < bnd_b) ? 2'd1 : 2'd2;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      cnt_upd[i] = cnt_r[i];
      if (q_item_i.dark && (bin_sel == 2'(i)) && (LIM_W'(cnt_r[i]) < lim)) begin
        cnt_upd[i] = cnt_r[i] + 1'b1;
      end
      populated[i] = (cnt_upd[i] > cfg_i.min_count);
    end
  end

  always_comb begin
    if (!populated[0]) begin
      run_cut = mid_h;
    end else if (!populated[1]) begin
      run_cut = mid_m;
    end else if (!populated[2]) begin
      run_cut = mid_l;
    end else begin
      run_cut = cfg_i.y_max;
    end
  end

  assign bad = (cfg_i.y_min >= cfg_i.y_max) ||
               (bgtm_pkg::HGT_W'(cfg_i.y_max) >= cfg_i.image_height);
  assign col_done = q_item_i.column_end || q_item_i.image_end;
  assign dark_col = col_dark_r || q_item_i.dark;

  always_comb begin
    in_run_nxt    = in_run_r;
    col_dark_nxt  = col_dark_r;
    cnt_nxt       = cnt_r;
    cur_col_nxt   = cur_col_r;
    run_start_nxt = run_start_r;
    run_cols_nxt  = run_cols_r;
    emit          = 1'b0;
    emit_err      = 1'b0;
    emit_start    = '0;
    emit_len      = '0;
    emit_cut      = '0;
    if (fire) begin
      cnt_nxt      = cnt_upd;
      col_dark_nxt = dark_col;
      if (col_done) begin
        if (bad) begin
          emit       = 1'b1;
          emit_err   = 1'b1;
          in_run_nxt = 1'b0;
        end else if (in_run_r) begin
          if (run_cols_r < CAP) begin
            run_cols_nxt = run_cols_r + 1'b1;
          end
          if (!dark_col || q_item_i.image_end) begin
            emit       = 1'b1;
            emit_start = run_start_r;
            emit_len   = run_cols_nxt;
            emit_cut   = run_cut;
            in_run_nxt = 1'b0;
          end
        end else if (dark_col) begin
          in_run_nxt    = 1'b1;
          run_start_nxt = cur_col_r;
          run_cols_nxt  = LEN_W'(1);
          if (q_item_i.image_end) begin
            emit       = 1'b1;
            emit_start = cur_col_r;
            emit_len   = LEN_W'(1);
            emit_cut   = run_cut;
            in_run_nxt = 1'b0;
          end
        end else begin
          // lone empty column, cut at the middle midpoint
          emit       = 1'b1;
          emit_start = cur_col_r;
          emit_len   = LEN_W'(1);
          emit_cut   = mid_m;
        end
        col_dark_nxt = 1'b0;
        if (!in_run_nxt) begin
          for (int i = 0; i < NB; i++) begin
            cnt_nxt[i] = '0;
          end
          run_cols_nxt = '0;
        end
        cur_col_nxt = q_item_i.image_end ? '0 : cur_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r    <= 1'b0;
      col_dark_r  <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        cnt_r[i] <= '0;
      end
      cur_col_r   <= '0;
      run_start_r <= '0;
      run_cols_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_run_r    <= in_run_nxt;
      col_dark_r  <= col_dark_nxt;
      cnt_r       <= cnt_nxt;
      cur_col_r   <= cur_col_nxt;
      run_start_r <= run_start_nxt;
      run_cols_r  <= run_cols_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_err_r   <= emit_err;
      out_start_r <= emit_start;
      out_len_r   <= emit_len;
      out_cut_r   <= emit_cut;
    end
  end

  assign out_valid_o    = out_valid_r;
  assign start_column_o = out_start_r;
  assign run_length_o   = out_len_r;
  assign cut_row_o      = out_cut_r;
  assign config_error_o = out_err_r;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> (out_start_r == '0) && (out_len_r == '0) && (out_cut_r == '0))
    else $error("error transaction carries nonzero fields");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_err_r |-> (out_len_r != '0))
    else $error("result with zero run length");
  assert property (@(posedge clk) disable iff (!rst_n) !in_run_r |-> (run_cols_r == '0))
    else $error("column count left over outside a run");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready_i && !emit |=> out_valid_r && $stable(out_len_r))
    else $error("pending result dropped or changed");
`endif

endmodule

// ----- src/band_gap_trace_midpoint.sv -----
// band_gap_trace_midpoint: top level with configuration registers and the three stages
// depends on bgtm_pkg, bgtm_front, bgtm_queue, bgtm_back
`timescale 1ns / 1ps

// Takes one grey pixel per clock while in_tready is high, in column-major order, and at
// the last pixel of a column may produce one result (start column, run length, cut row,
// error flag). Sustained rate is one pixel per cycle while out_tready is high: the back
// stage updates the bin counts and the run state for one pixel each cycle. A result
// passes the input register, the queue and the result register after the column's
// last pixel is accepted. The bin width floor((y_max-y_min)/3) is registered in the
// cycle after a configuration write. Registers: y_min at 0x00, y_max at 0x04,
// image_height at 0x08, dark_threshold at 0x0c, min_count at 0x10.
module band_gap_trace_midpoint #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: pixel [7:0], row [19:8], zero [23:20]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tlast,   // image_end
  input  logic        in_tuser,   // column_end
  // out_tdata: start_column [11:0], run_length [24:12], cut_row [36:25], zero [39:37]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tuser,  // config_error
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bgtm_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [bgtm_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [bgtm_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int unsigned RUN_CAP = (MAX_DIM < 8191) ? MAX_DIM : 8191;
  localparam int unsigned ROW_W   = bgtm_pkg::ROW_W;
  localparam int unsigned DATA_W  = bgtm_pkg::DATA_W;

  logic [ROW_W-1:0]           y_min_r, y_max_r;
  logic [bgtm_pkg::HGT_W-1:0] height_r;
  logic [bgtm_pkg::PIX_W-1:0] thresh_r;
  logic [bgtm_pkg::CNT_W-1:0] min_cnt_r;
  logic [bgtm_pkg::D_W-1:0]   d_r, d_nxt;
  logic [ROW_W-1:0]           diff;
  logic [bgtm_pkg::PROD_W-1:0] prod;
  logic                       wr_en;
  bgtm_pkg::reg_idx_t         reg_idx;
  bgtm_pkg::cfg_t             cfg;

  logic                       q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  bgtm_pkg::item_t            q_push_item, q_pop_item;
  logic [bgtm_pkg::COL_W-1:0] res_start;
  logic [bgtm_pkg::LEN_W-1:0] res_len;
  logic [ROW_W-1:0]           res_cut;

  assign cfg_pready = 1'b1;
  assign reg_idx    = bgtm_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_min_r   <= bgtm_pkg::Y_MIN_RST;
      y_max_r   <= bgtm_pkg::Y_MAX_RST;
      height_r  <= bgtm_pkg::HEIGHT_RST;
      thresh_r  <= bgtm_pkg::THRESH_RST;
      min_cnt_r <= bgtm_pkg::MIN_CNT_RST;
      d_r       <= bgtm_pkg::D_RST;
    end else begin
      d_r <= d_nxt;
      if (wr_en) begin
        case (reg_idx)
          bgtm_pkg::REG_Y_MIN:     y_min_r   <= cfg_pwdata[ROW_W-1:0];
          bgtm_pkg::REG_Y_MAX:     y_max_r   <= cfg_pwdata[ROW_W-1:0];
          bgtm_pkg::REG_HEIGHT:    height_r  <= cfg_pwdata[bgtm_pkg::HGT_W-1:0];
          bgtm_pkg::REG_THRESHOLD: thresh_r  <= cfg_pwdata[bgtm_pkg::PIX_W-1:0];
          bgtm_pkg::REG_MIN_COUNT: min_cnt_r <= cfg_pwdata[bgtm_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      bgtm_pkg::REG_Y_MIN:     cfg_prdata = DATA_W'(y_min_r);
      bgtm_pkg::REG_Y_MAX:     cfg_prdata = DATA_W'(y_max_r);
      bgtm_pkg::REG_HEIGHT:    cfg_prdata = DATA_W'(height_r);
      bgtm_pkg::REG_THRESHOLD: cfg_prdata = DATA_W'(thresh_r);
      bgtm_pkg::REG_MIN_COUNT: cfg_prdata = DATA_W'(min_cnt_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // bin width by reciprocal multiply
  assign diff  = y_max_r - y_min_r;
  assign prod  = bgtm_pkg::PROD_W'(diff) * bgtm_pkg::PROD_W'(bgtm_pkg::RECIP3);
  assign d_nxt = prod[bgtm_pkg::RECIP_SHIFT +: bgtm_pkg::D_W];

  assign cfg.y_min          = y_min_r;
  assign cfg.y_max          = y_max_r;
  assign cfg.image_height   = height_r;
  assign cfg.dark_threshold = thresh_r;
  assign cfg.min_count      = min_cnt_r;
  assign cfg.d              = d_r;

  bgtm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .pixel_i      (in_tdata[7:0]),
    .row_i        (in_tdata[19:8]),
    .column_end_i (in_tuser),
    .image_end_i  (in_tlast),
    .q_valid_o    (q_push_valid),
    .q_ready_i    (q_push_ready),
    .q_item_o     (q_push_item)
  );

  bgtm_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_item_i  (q_push_item),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_item_o   (q_pop_item)
  );

  bgtm_back #(
    .RUN_CAP (RUN_CAP)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg),
    .q_valid_i      (q_pop_valid),
    .q_ready_o      (q_pop_ready),
    .q_item_i       (q_pop_item),
    .out_valid_o    (out_tvalid),
    .out_ready_i    (out_tready),
    .start_column_o (res_start),
    .run_length_o   (res_len),
    .cut_row_o      (res_cut),
    .config_error_o (out_tuser)
  );

  assign out_tdata = {3'b000, res_cut, res_len, res_start};

endmodule
